// ===== rtl/sorted_key_table_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted key table engine - assertion macros
// Concurrent check helpers clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ENGINE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_ENGINE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SKTE_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("skte same-cycle check failed");

// next-cycle implication
`define SKTE_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skte next-cycle check failed");

`else

`define SKTE_CHECK_NOW(name, ante, cons)
`define SKTE_CHECK_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/skte_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table engine - package
// Request/response structs, operation and status codes, cell command type.
// ----------------------------------------------------------------------------
`default_nettype none

package skte_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_POP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_NULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_mode                      mode;
        logic signed [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0]        handle;
    } t_req;

    typedef struct packed {
        t_status                    status;
        logic [HANDLE_W-1:0]        found_handle;
        logic signed [KEY_W-1:0]    found_key;
        logic [POS_W-1:0]           position;
        logic [COUNT_W-1:0]         entry_count;
        logic                       is_empty;
    } t_resp;

    typedef struct packed {
        logic signed [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0]        handle;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op                   op;
        t_entry                     ent;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/sorted_key_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// Sorted key table engine core
// Sorted (key, handle) table built as a chain of cells with a halving search.
// ----------------------------------------------------------------------------
// Sequence: accept, SEARCH, APPLY, then the registered o_valid strobe. Pop and
//   rejected inserts leave SEARCH without a halving step; inserts and search misses
//   run every halving step plus a closing one, a delete or lookup hit stops at the
//   hitting step (at most $clog2(CAPACITY+1) steps). Busy stays high through apply.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset: synchronous, active low; empties the table (cell valid bits, count).
`default_nettype none
`include "sorted_key_table_engine_core_macros.svh"

module sorted_key_table_engine_core #(
    parameter int CAPACITY = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  skte_pkg::t_req  i_req,
    output logic            o_valid,
    output skte_pkg::t_resp o_resp
);
    import skte_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // cell index
    localparam int CW = $clog2(CAPACITY + 1);                   // entry count

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    t_state        r_state, n_state;
    t_req          r_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo;       // search low bound
    logic [CW-1:0] r_hip1, n_hip1;   // search high bound plus one
    logic [IW-1:0] r_pos, n_pos;     // target slot for apply
    logic          r_hit, n_hit;     // search hit / insert allowed
    t_resp         r_out, n_out;
    logic          r_out_vld, n_out_vld;

    // ---------------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------------
    t_cell_cmd             cell_cmd;
    t_entry                ent_q [CAPACITY];
    t_entry                rd_q  [CAPACITY];
    logic [CAPACITY-1:0]   vld_vec;
    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;
    t_entry                rd_data;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry prev_ent, next_ent;
        logic   prev_vld, next_vld;

        if (g == 0) begin : g_head
            assign prev_ent = '0;
            assign prev_vld = 1'b0;
        end else begin : g_mid_prev
            assign prev_ent = ent_q[g-1];
            assign prev_vld = vld_vec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_ent = '0;
            assign next_vld = 1'b0;
        end else begin : g_mid_next
            assign next_ent = ent_q[g+1];
            assign next_vld = vld_vec[g+1];
        end

        skte_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cell_cmd),
            .i_pos      (r_pos),
            .i_prev_ent (prev_ent),
            .i_prev_vld (prev_vld),
            .i_next_ent (next_ent),
            .i_next_vld (next_vld),
            .o_ent      (ent_q[g]),
            .o_vld      (vld_vec[g]),
            .o_lt       (lt_vec[g]),
            .o_eq       (eq_vec[g]),
            .o_rd       (rd_q[g])
        );
    end

    // only the cell at r_pos drives a nonzero readout: OR them together
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | rd_q[i];
        end
    end

    // ---------------------------------------------------------------------
    // Halving search step: mid = (lo + hi) / 2 with hi = hip1 - 1
    // ---------------------------------------------------------------------
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [IW-1:0] mid_idx;
    logic          mid_lt, mid_eq;
    logic          table_full;
    logic          ins_reject;

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hip1} - {{CW{1'b0}}, 1'b1};
    assign mid        = mid_sum[CW:1];
    assign mid_idx    = mid[IW-1:0];
    assign mid_lt     = lt_vec[mid_idx];
    assign mid_eq     = eq_vec[mid_idx];
    assign table_full = (r_count == CW'(CAPACITY));
    assign ins_reject = (r_req.handle == '0) || table_full;

    // ---------------------------------------------------------------------
    // Sequencer: IDLE -> SEARCH (one halving step per cycle) -> APPLY
    // ---------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hip1       = r_hip1;
        n_pos        = r_pos;
        n_hit        = r_hit;
        n_out        = r_out;
        n_out_vld    = 1'b0;
        cell_cmd.op  = CELL_HOLD;
        cell_cmd.ent = '{key: r_req.key, handle: r_req.handle};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_lo    = '0;
                    n_hip1  = r_count;
                    n_state = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                if (r_req.mode == MODE_POP) begin
                    n_pos   = IW'(r_count - CW'(1));
                    n_hit   = (r_count != '0);
                    n_state = ST_APPLY;
                end else if (r_req.mode == MODE_INSERT) begin
                    if (ins_reject) begin
                        n_hit   = 1'b0;
                        n_state = ST_APPLY;
                    end else if (r_lo < r_hip1) begin
                        // lower bound: move past keys that are below the request
                        if (mid_lt) begin
                            n_lo = mid + CW'(1);
                        end else begin
                            n_hip1 = mid;
                        end
                    end else begin
                        n_pos   = r_lo[IW-1:0];
                        n_hit   = 1'b1;
                        n_state = ST_APPLY;
                    end
                end else begin
                    // delete / lookup: stop at the first equal midpoint
                    if (r_lo < r_hip1) begin
                        if (mid_eq) begin
                            n_pos   = mid_idx;
                            n_hit   = 1'b1;
                            n_state = ST_APPLY;
                        end else if (mid_lt) begin
                            n_lo = mid + CW'(1);
                        end else begin
                            n_hip1 = mid;
                        end
                    end else begin
                        n_hit   = 1'b0;
                        n_state = ST_APPLY;
                    end
                end
            end

            ST_APPLY: begin
                n_out.status       = STAT_OK;
                n_out.found_handle = '0;
                n_out.found_key    = '0;
                n_out.position     = '0;

                case (r_req.mode)
                    MODE_INSERT: begin
                        if (r_req.handle == '0) begin
                            n_out.status = STAT_NULL;
                        end else if (table_full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            cell_cmd.op    = CELL_INS;
                            n_out.position = POS_W'(r_pos);
                            n_count        = r_count + CW'(1);
                        end
                    end
                    MODE_DELETE: begin
                        if (r_hit) begin
                            cell_cmd.op    = CELL_DEL;
                            n_out.position = POS_W'(r_pos);
                            n_count        = r_count - CW'(1);
                        end else begin
                            n_out.status = STAT_MISS;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (r_hit) begin
                            n_out.position     = POS_W'(r_pos);
                            n_out.found_handle = rd_data.handle;
                            n_out.found_key    = rd_data.key;
                        end else begin
                            n_out.status = STAT_MISS;
                        end
                    end
                    default: begin
                        // pop last
                        if (r_hit) begin
                            cell_cmd.op        = CELL_POP;
                            n_out.position     = POS_W'(r_pos);
                            n_out.found_handle = rd_data.handle;
                            n_out.found_key    = rd_data.key;
                            n_count            = r_count - CW'(1);
                        end else begin
                            n_out.status = STAT_MISS;
                        end
                    end
                endcase

                n_out.entry_count = COUNT_W'(n_count);
                n_out.is_empty    = (n_count == '0);
                n_out_vld         = 1'b1;
                n_state           = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req <= i_req;
        end
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        r_pos  <= n_pos;
        r_hit  <= n_hit;
        r_out  <= n_out;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_resp  = r_out;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // every apply cycle is followed by a result strobe
    `SKTE_CHECK_NEXT(a_strobe_from_apply, r_state == ST_APPLY, o_valid)
    // valid bits across the chain agree with the entry count
    `SKTE_CHECK_NOW(a_count_matches_cells, 1'b1, $countones(vld_vec) == r_count)
    // an accepted insert (only issued in apply) grows the table by exactly one
    `SKTE_CHECK_NEXT(a_insert_grows, cell_cmd.op == CELL_INS, r_count == $past(r_count) + CW'(1))
    // the search never leaves its bounds past the entry count
    `SKTE_CHECK_NOW(a_search_bounds, r_state == ST_SEARCH, (r_hip1 <= r_count) && (r_lo <= r_count))

endmodule

`default_nettype wire

// ===== rtl/skte_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key table engine - table cell
// One table slot: holds an entry and its valid bit, compares against the
// broadcast key and shifts up or down with its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module skte_cell #(
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skte_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]       i_pos,
    input  skte_pkg::t_entry    i_prev_ent,
    input  logic                i_prev_vld,
    input  skte_pkg::t_entry    i_next_ent,
    input  logic                i_next_vld,
    output skte_pkg::t_entry    o_ent,
    output logic                o_vld,
    output logic                o_lt,
    output logic                o_eq,
    output skte_pkg::t_entry    o_rd
);
    import skte_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_entry r_ent, n_ent;
    logic   r_vld, n_vld;
    logic   at_pos, above_pos;

    assign at_pos    = (MY_IDX == i_pos);
    assign above_pos = (MY_IDX > i_pos);

    always_comb begin
        n_ent = r_ent;
        n_vld = r_vld;
        case (i_cmd.op)
            CELL_INS: begin
                if (at_pos) begin
                    n_ent = i_cmd.ent;
                    n_vld = 1'b1;
                end else if (above_pos) begin
                    n_ent = i_prev_ent;
                    n_vld = i_prev_vld;
                end
            end
            CELL_DEL: begin
                if (at_pos || above_pos) begin
                    n_ent = i_next_ent;
                    n_vld = i_next_vld;
                end
            end
            CELL_POP: begin
                if (at_pos) begin
                    n_vld = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;
    assign o_vld = r_vld;
    assign o_lt  = r_vld && (r_ent.key < i_cmd.ent.key);
    assign o_eq  = r_vld && (r_ent.key == i_cmd.ent.key);
    assign o_rd  = at_pos ? r_ent : '0;

endmodule

`default_nettype wire

// ===== test/tb_sorted_key_table_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table engine core - testbench
// Drives insert, delete, lookup and pop requests through the start/busy
// handshake, mirrors the sorted table in a scoreboard and checks every
// response field. Runs a directed opener, a mixed random phase, a fill to
// capacity with rejected inserts, and a draining phase.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_engine_core;

    import skte_pkg::*;

    localparam int CAPACITY    = 256;
    localparam int QUIET_LIMIT = 5000;  // cycles with no request or response
    localparam int DRAIN_TAIL  = 40;    // cycles after the last response

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the sorted table plus the queue of responses
    // still owed by the block.
    // ------------------------------------------------------------------------
    class key_table_tracker #(int DEPTH = 256);
        logic signed [KEY_W-1:0] keys [DEPTH];
        logic [HANDLE_W-1:0]     handles [DEPTH];
        int                      fill;
        int                      n_fail;
        int                      n_seen;
        t_resp                   pending_resp [$];

        function new();
            fill   = 0;
            n_fail = 0;
            n_seen = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            n_fail++;
        endtask

        // halving search, midpoint rounded down; first equal key it reaches
        function int halving_hit(logic signed [KEY_W-1:0] k, output int idx);
            int lo;
            int hi;
            int mid;
            lo  = 0;
            hi  = fill - 1;
            idx = 0;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] == k) begin
                    idx = mid;
                    return 1;
                end else if (keys[mid] > k) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            return 0;
        endfunction

        // first slot whose key is not below k
        function int lower_slot(logic signed [KEY_W-1:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = fill - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return lo;
        endfunction

        function void note_request(t_req r);
            t_resp want;
            int    pos;
            int    i;
            want        = '0;
            want.status = STAT_OK;
            pos         = 0;
            case (r.mode)
                MODE_INSERT: begin
                    if (r.handle == '0) begin
                        want.status = STAT_NULL;
                    end else if (fill >= DEPTH) begin
                        want.status = STAT_FULL;
                    end else begin
                        pos = lower_slot(r.key);
                        for (i = fill; i > pos; i--) begin
                            keys[i]    = keys[i-1];
                            handles[i] = handles[i-1];
                        end
                        keys[pos]    = r.key;
                        handles[pos] = r.handle;
                        fill++;
                    end
                end
                MODE_DELETE: begin
                    if (halving_hit(r.key, pos)) begin
                        for (i = pos; i + 1 < fill; i++) begin
                            keys[i]    = keys[i+1];
                            handles[i] = handles[i+1];
                        end
                        fill--;
                    end else begin
                        want.status = STAT_MISS;
                        pos         = 0;
                    end
                end
                MODE_LOOKUP: begin
                    if (halving_hit(r.key, pos)) begin
                        want.found_handle = handles[pos];
                        want.found_key    = keys[pos];
                    end else begin
                        want.status = STAT_MISS;
                        pos         = 0;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        want.status = STAT_MISS;
                    end else begin
                        fill--;
                        pos               = fill;
                        want.found_handle = handles[pos];
                        want.found_key    = keys[pos];
                    end
                end
            endcase
            want.position    = POS_W'(pos);
            want.entry_count = COUNT_W'(fill);
            want.is_empty    = (fill == 0);
            pending_resp.push_back(want);
        endfunction

        task check_result(t_resp got);
            t_resp want;
            if (pending_resp.size() == 0) begin
                report($sformatf("response with no request outstanding: %h", got));
            end else begin
                want = pending_resp.pop_front();
                if (got.status !== want.status)
                    report($sformatf("rsp %0d status got %0d exp %0d",
                                     n_seen, got.status, want.status));
                if (got.found_handle !== want.found_handle)
                    report($sformatf("rsp %0d found_handle got %h exp %h",
                                     n_seen, got.found_handle, want.found_handle));
                if (got.found_key !== want.found_key)
                    report($sformatf("rsp %0d found_key got %h exp %h",
                                     n_seen, got.found_key, want.found_key));
                if (got.position !== want.position)
                    report($sformatf("rsp %0d position got %0d exp %0d",
                                     n_seen, got.position, want.position));
                if (got.entry_count !== want.entry_count)
                    report($sformatf("rsp %0d entry_count got %0d exp %0d",
                                     n_seen, got.entry_count, want.entry_count));
                if (got.is_empty !== want.is_empty)
                    report($sformatf("rsp %0d is_empty got %b exp %b",
                                     n_seen, got.is_empty, want.is_empty));
            end
            n_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_resp o_resp;

    key_table_tracker #(CAPACITY) tracker;
    int burst_left;

    sorted_key_table_engine_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_resp  (o_resp)
    );

    // 100 MHz
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side: the strobe cannot be held off, so every o_valid
    // cycle is a response to check.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            tracker.check_result(o_resp);
        end
    end

    // Watchdog: give up after a long stretch with no handshake on either side.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    function automatic t_req mk(t_mode m, logic signed [KEY_W-1:0] k,
                                logic [HANDLE_W-1:0] h);
        t_req r;
        r.mode   = m;
        r.key    = k;
        r.handle = h;
        return r;
    endfunction

    // Keys from a small pool so they repeat, some extremes, half anywhere.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       k = 32'sh8000_0000;
                    1:       k = 32'sh7FFF_FFFF;
                    2:       k = '0;
                    3:       k = -32'sd1;
                    default: k = 32'sd1;
                endcase
            end
            1, 2, 3, 4: k = KEY_W'($urandom_range(0, 23)) - 32'sd12;
            default:    k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 19) == 0) return '0;
        return HANDLE_W'($urandom_range(1, 16'hFFFF));
    endfunction

    // weights in percent for insert, delete, lookup; pop takes the rest
    function automatic t_req rand_req(int w_ins, int w_del, int w_look);
        t_req r;
        int   roll;
        roll     = $urandom_range(0, 99);
        r.key    = pick_key();
        r.handle = pick_handle();
        if (roll < w_ins)                       r.mode = MODE_INSERT;
        else if (roll < w_ins + w_del)          r.mode = MODE_DELETE;
        else if (roll < w_ins + w_del + w_look) r.mode = MODE_LOOKUP;
        else                                    r.mode = MODE_POP;
        // searches mostly aim at keys that are present
        if ((r.mode == MODE_DELETE || r.mode == MODE_LOOKUP) && tracker.fill > 0
                && $urandom_range(0, 9) < 6) begin
            r.key = tracker.keys[$urandom_range(0, tracker.fill - 1)];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks: inputs move on the falling edge, handshake is judged
    // on the rising edge.
    // ------------------------------------------------------------------------
    task automatic idle_for(int n);
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= {2'($urandom), $urandom, 16'($urandom)};  // junk while start is low
        repeat (n - 1) @(negedge i_clk);
    endtask

    // start stays high across back-to-back requests inside a burst
    task automatic issue(t_req r);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(r);
        burst_left--;
    endtask

    // hold off until every outstanding response is back
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_resp.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        start      = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        burst_left = 0;
        tracker    = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: pop, lookup and delete all miss
        issue(mk(MODE_POP,    32'sd0,  16'h0000));
        issue(mk(MODE_LOOKUP, 32'sd0,  16'hFFFF));
        issue(mk(MODE_DELETE, 32'sd5,  16'h0001));
        // null handle rejected, table untouched
        issue(mk(MODE_INSERT, 32'sd7,  16'h0000));
        // key and handle extremes
        issue(mk(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF));
        issue(mk(MODE_INSERT, 32'sh8000_0000, 16'h0001));
        issue(mk(MODE_INSERT, 32'sd0,  16'h8000));
        issue(mk(MODE_INSERT, -32'sd1, 16'h7FFF));
        // equal keys land in front of existing ones
        issue(mk(MODE_INSERT, 32'sd0,  16'h1234));
        issue(mk(MODE_INSERT, 32'sd0,  16'h00AA));
        // lookups: duplicate, both ends, a miss, a handle that is ignored
        issue(mk(MODE_LOOKUP, 32'sd0,  16'h0000));
        issue(mk(MODE_LOOKUP, 32'sh8000_0000, 16'h0000));
        issue(mk(MODE_LOOKUP, 32'sh7FFF_FFFF, 16'h0000));
        issue(mk(MODE_LOOKUP, 32'sd5,  16'h0000));
        issue(mk(MODE_LOOKUP, -32'sd1, 16'hFFFF));
        // deletes: one duplicate, a miss, the minimum
        issue(mk(MODE_DELETE, 32'sd0,  16'h0000));
        issue(mk(MODE_DELETE, 32'sd100, 16'h0000));
        issue(mk(MODE_DELETE, 32'sh8000_0000, 16'hFFFF));
        // pop everything, then once more on the empty table
        issue(mk(MODE_POP, 32'sd0, 16'h0000));
        issue(mk(MODE_POP, 32'sd0, 16'h0000));
        issue(mk(MODE_POP, 32'sd0, 16'h0000));
        issue(mk(MODE_POP, 32'sd0, 16'h0000));
        issue(mk(MODE_POP, 32'sh7FFF_FFFF, 16'hFFFF));

        // mixed traffic that lets the table grow slowly
        repeat (200) issue(rand_req(40, 20, 25));
        settle();

        // fill to capacity, with a few lookups along the way
        while (tracker.fill < CAPACITY) begin
            if ($urandom_range(0, 9) == 0) begin
                issue(rand_req(0, 0, 100));
            end else begin
                issue(mk(MODE_INSERT, pick_key(), HANDLE_W'($urandom_range(1, 16'hFFFF))));
            end
        end
        // full table: inserts bounce, null handle still reported as null
        for (int n = 0; n < 6; n++) begin
            issue(mk(MODE_INSERT, pick_key(),
                     (n % 3 == 0) ? 16'h0000 : HANDLE_W'($urandom_range(1, 16'hFFFF))));
        end
        issue(mk(MODE_LOOKUP, tracker.keys[CAPACITY-1], 16'h0000));
        issue(mk(MODE_LOOKUP, tracker.keys[0], 16'h0000));
        issue(mk(MODE_POP, 32'sd0, 16'h0000));       // pops from the top slot
        issue(mk(MODE_INSERT, pick_key(), 16'hFFFF)); // back to full
        issue(mk(MODE_INSERT, pick_key(), 16'h0001)); // rejected
        settle();

        // drain-heavy traffic
        repeat (160) issue(rand_req(10, 40, 20));

        // wrap up
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (tracker.pending_resp.size() != 0) begin
            tracker.report($sformatf("%0d responses never arrived",
                                     tracker.pending_resp.size()));
        end
        if (tracker.n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
